// ===== design/nalsp_pkg.sv =====
// Shared types and constants for the Annex B start-code splitter.
package nalsp_pkg;

	localparam int BYTE_W     = 8;
	localparam int UNIT_LEN_W = 24;
	localparam int TDATA_W    = 48;
	localparam int TUSER_W    = 2;

	localparam logic [UNIT_LEN_W-1:0] OUT_LEN_MAX = '1;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// start code tail and zero byte
	localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;
	localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;

	typedef struct packed {
		logic                    end_of_stream;
		logic [BYTE_W-1:0]       stream_byte;
	} item_t;

	// held input item as seen by the engine
	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	typedef struct packed {
		logic                    kind;
		logic [BYTE_W-1:0]       payload_byte;
		logic                    first_of_unit;
		logic [UNIT_LEN_W-1:0]   unit_length;
		logic                    length_saturated;
		logic                    long_prefix;
		logic                    hdr_top_bit;
		logic [1:0]              reference_priority;
		logic [4:0]              unit_type;
		logic                    last_result;
	} result_t;

	// result offered by the engine to the output register
	typedef struct packed {
		logic    valid;
		result_t res;
	} res_req_t;

endpackage

// ===== design/annexb_nal_unit_splitter_top.sv =====
// Top level of the Annex B start-code NAL unit splitter.
//
//  channel | dir | tdata                         | tuser                  | tlast
//  --------+-----+-------------------------------+------------------------+--------------
//  s_*     | in  | [7:0] stream byte             | -                      | end of stream
//  m_*     | out | payload, length, flags, header| [0] kind [1] first byte| last result
//
//  At most one byte transaction is taken per cycle, and only once the held byte is done;
//  a byte may yield several results. The output register takes one result per cycle while
//  m_tready allows, so the engine holds a byte until its last result is taken; an
//  end-of-stream byte also takes its own step, then window flush and close.
//  A byte is registered in the input register, and its result in the output register.
//  arst_n clears all unit state; the splitter then hunts for the first start code.
//  A stall on m_tready holds the engine and, through it, s_tready.
module annexb_nal_unit_splitter_top
	import nalsp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 24
)
(
	input  logic               clk,
	input  logic               arst_n,
	// slave side
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] stream_byte
	input  logic               s_tlast,   // end_of_stream
	// master side
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] payload_byte, [31:8] unit_length, [32] length_saturated,
	// [33] long_prefix, [34] hdr_top_bit, [36:35] reference_priority,
	// [41:37] unit_type, [47:42] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser,   // [0] kind, [1] first_of_unit
	output logic               m_tlast    // last_result
);

	item_t    in_item;
	stage_t   stage;
	res_req_t req;
	result_t  out_res;
	logic     item_done;
	logic     out_free;

	assign in_item.stream_byte   = s_tdata;
	assign in_item.end_of_stream = s_tlast;

	nalsp_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.item_done (item_done),
		.stage     (stage)
	);

	// start-code search, window, length count and header capture
	nalsp_engine #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.out_free  (out_free),
		.item_done (item_done),
		.req       (req)
	);

	nalsp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// header fields come from bit 7, bits 6..5 and bits 4..0 of the first unit byte
	assign m_tdata = {6'b0, out_res.unit_type, out_res.reference_priority,
	                  out_res.hdr_top_bit, out_res.long_prefix,
	                  out_res.length_saturated, out_res.unit_length,
	                  out_res.payload_byte};
	assign m_tuser = {out_res.first_of_unit, out_res.kind};
	assign m_tlast = out_res.last_result;

endmodule

// ===== design/nalsp_in_reg.sv =====
// Input holding register: one byte transaction waits here until the engine finishes it.
module nalsp_in_reg
	import nalsp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  item_t  in_item,
	input  logic   item_done,
	output stage_t stage
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (item_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

// ===== design/nalsp_engine.sv =====
// Splitter state and per-cycle step: at most one result per cycle.
module nalsp_engine
	import nalsp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 24
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  stage_t   stage,
	input  logic     out_free,
	output logic     item_done,
	output res_req_t req
);

	localparam int LenExtW = (LENGTH_WIDTH > UNIT_LEN_W) ? LENGTH_WIDTH : UNIT_LEN_W;

	typedef enum logic [1:0] {P_MAIN, P_CLOSE, P_FLUSH} phase_t;

	phase_t                  phase_q,  phase_d;
	logic                    lnext_q,  lnext_d;
	logic [2:0][BYTE_W-1:0]  win_q,    win_d;
	logic [1:0]              cnt_q,    cnt_d;
	logic                    inside_q, inside_d;
	logic [LENGTH_WIDTH-1:0] len_q,    len_d;
	logic                    sat_q,    sat_d;
	logic [BYTE_W-1:0]       hdr_q,    hdr_d;
	logic                    long_q,   long_d;

	logic              go;
	logic              four, three, is_one;
	logic              emit_pay, emit_end, more;
	logic [BYTE_W-1:0] pay_byte;
	logic              pay_first;
	logic [LenExtW-1:0] len_ext;
	logic              len_over;
	logic [BYTE_W-1:0] b;
	logic              eos;
	result_t           res;

	assign go  = stage.valid && out_free;
	assign b   = stage.item.stream_byte;
	assign eos = stage.item.end_of_stream;

	assign is_one = (b == SC_ONE);
	assign four   = (cnt_q == 2'd3) && (win_q[0] == SC_ZERO) && (win_q[1] == SC_ZERO)
	                && (win_q[2] == SC_ZERO) && is_one;
	always_comb begin
		case (cnt_q)
			2'd2:    three = !four && is_one && (win_q[0] == SC_ZERO) && (win_q[1] == SC_ZERO);
			2'd3:    three = !four && is_one && (win_q[1] == SC_ZERO) && (win_q[2] == SC_ZERO);
			default: three = 1'b0;
		endcase
	end

	assign pay_first = (len_q == '0) && !sat_q;
	assign len_ext   = LenExtW'(len_q);
	assign len_over  = len_ext > LenExtW'(OUT_LEN_MAX);

	always_comb begin
		phase_d   = phase_q;
		lnext_d   = lnext_q;
		win_d     = win_q;
		cnt_d     = cnt_q;
		inside_d  = inside_q;
		len_d     = len_q;
		sat_d     = sat_q;
		hdr_d     = hdr_q;
		long_d    = long_q;
		emit_pay  = 1'b0;
		emit_end  = 1'b0;
		pay_byte  = win_q[0];
		more      = 1'b0;
		item_done = 1'b0;

		if (go) begin
			unique case (phase_q)
				P_MAIN: begin
					if ((four || three) && three && cnt_q == 2'd3 && inside_q) begin
						// oldest window byte still belongs to the closing unit
						emit_pay = 1'b1;
						lnext_d  = 1'b0;
						phase_d  = P_CLOSE;
						more     = 1'b1;
					end else if (four || three) begin
						emit_end = inside_q;
						inside_d = 1'b1;
						len_d    = '0;
						sat_d    = 1'b0;
						hdr_d    = '0;
						long_d   = four;
						win_d    = '0;
						cnt_d    = 2'd0;
						more     = eos;
						if (eos) begin
							phase_d = P_FLUSH;
						end else begin
							item_done = 1'b1;
						end
					end else begin
						if (cnt_q == 2'd3) begin
							emit_pay = inside_q;
							win_d[0] = win_q[1];
							win_d[1] = win_q[2];
							win_d[2] = b;
						end else begin
							case (cnt_q)
								2'd0:    win_d[0] = b;
								2'd1:    win_d[1] = b;
								default: win_d[2] = b;
							endcase
							cnt_d = cnt_q + 2'd1;
						end
						more = eos && inside_q;
						if (eos) begin
							phase_d = P_FLUSH;
						end else begin
							item_done = 1'b1;
						end
					end
				end
				P_CLOSE: begin
					emit_end = inside_q;
					inside_d = 1'b1;
					len_d    = '0;
					sat_d    = 1'b0;
					hdr_d    = '0;
					long_d   = lnext_q;
					win_d    = '0;
					cnt_d    = 2'd0;
					more     = eos;
					if (eos) begin
						phase_d = P_FLUSH;
					end else begin
						phase_d   = P_MAIN;
						item_done = 1'b1;
					end
				end
				P_FLUSH: begin
					if (inside_q && cnt_q != 2'd0) begin
						emit_pay = 1'b1;
						win_d[0] = win_q[1];
						win_d[1] = win_q[2];
						win_d[2] = SC_ZERO;
						cnt_d    = cnt_q - 2'd1;
						more     = 1'b1;
					end else begin
						emit_end  = inside_q;
						inside_d  = 1'b0;
						len_d     = '0;
						sat_d     = 1'b0;
						hdr_d     = '0;
						long_d    = 1'b0;
						win_d     = '0;
						cnt_d     = 2'd0;
						phase_d   = P_MAIN;
						item_done = 1'b1;
					end
				end
				default: begin
					phase_d = P_MAIN;
				end
			endcase

			if (emit_pay) begin
				if (pay_first) begin
					hdr_d = pay_byte;
				end
				if (len_q == '1) begin
					sat_d = 1'b1;
				end else begin
					len_d = len_q + LENGTH_WIDTH'(1);
				end
			end
		end
	end

	always_comb begin
		res = '0;
		res.last_result = !more;
		if (emit_end) begin
			res.kind               = KIND_END;
			res.unit_length        = len_over ? OUT_LEN_MAX : len_ext[UNIT_LEN_W-1:0];
			res.length_saturated   = sat_q || len_over;
			res.long_prefix        = long_q;
			res.hdr_top_bit        = hdr_q[7];
			res.reference_priority = hdr_q[6:5];
			res.unit_type          = hdr_q[4:0];
		end else begin
			res.kind          = KIND_PAYLOAD;
			res.payload_byte  = pay_byte;
			res.first_of_unit = pay_first;
		end
	end

	assign req.valid = emit_pay || emit_end;
	assign req.res   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_MAIN;
			lnext_q  <= 1'b0;
			win_q    <= '0;
			cnt_q    <= 2'd0;
			inside_q <= 1'b0;
			len_q    <= '0;
			sat_q    <= 1'b0;
			hdr_q    <= '0;
			long_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			lnext_q  <= lnext_d;
			win_q    <= win_d;
			cnt_q    <= cnt_d;
			inside_q <= inside_d;
			len_q    <= len_d;
			sat_q    <= sat_d;
			hdr_q    <= hdr_d;
			long_q   <= long_d;
		end
	end

`ifndef SYNTHESIS
	a_sat_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> (len_q == '1))
		else $error("saturation flag set below counter maximum");

	a_idle_unit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!inside_q |-> ((len_q == '0) && !sat_q && !long_q && (hdr_q == '0)))
		else $error("unit bookkeeping not clear outside a unit");

	a_phase_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != P_MAIN) |-> stage.valid)
		else $error("follow-on phase without a held item");

	a_more_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && !req.res.last_result) |=> stage.valid)
		else $error("item released before its last result");
`endif

endmodule

// ===== design/nalsp_out_reg.sv =====
// Output result register on the master side.
module nalsp_out_reg
	import nalsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  res_req_t req,
	output logic     out_free,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  out_res
);

	logic    valid_q;
	result_t res_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && req.valid) begin
			res_q <= req.res;
		end
	end

endmodule

// ===== sim/nal_split_checker.sv =====
// Checker for the Annex B splitter: tracks stream bytes, predicts unit output and compares.
`timescale 1ns / 100ps

module nal_split_checker
	import nalsp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 24
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] stream_byte
	input  logic               s_tlast,   // end_of_stream
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [7:0] byte, [31:8] length, [32] sat, [33] long,
	                                      // [34] header top bit, [36:35] priority, [41:37] type
	input  logic [TUSER_W-1:0] m_tuser,   // [0] kind, [1] first_of_unit
	input  logic               m_tlast,   // last_result
	output int unsigned        mismatch_count,
	output int unsigned        awaited_count,
	output int unsigned        results_seen,
	output int unsigned        units_seen
);

	localparam logic [LENGTH_WIDTH-1:0] COUNT_TOP = '1;

	// splitter state as predicted
	logic [7:0]              win [3];
	int unsigned             win_fill;
	logic                    in_unit;
	logic [LENGTH_WIDTH-1:0] unit_len;
	logic                    len_sat;
	logic [7:0]              hdr_byte;
	logic                    long_code;

	result_t awaited_results [$];

	function automatic void clear_unit_state();
		win       = '{default: '0};
		win_fill  = 0;
		in_unit   = 1'b0;
		unit_len  = '0;
		len_sat   = 1'b0;
		hdr_byte  = '0;
		long_code = 1'b0;
	endfunction

	function automatic void emit_unit_byte(input logic [7:0] b);
		result_t r;
		if (!in_unit)
			return;
		r = '0;
		r.kind          = KIND_PAYLOAD;
		r.payload_byte  = b;
		r.first_of_unit = (unit_len == '0) && !len_sat;
		if (r.first_of_unit)
			hdr_byte = b;
		if (unit_len == COUNT_TOP)
			len_sat = 1'b1;
		else
			unit_len = unit_len + LENGTH_WIDTH'(1);
		awaited_results.push_back(r);
	endfunction

	function automatic void close_unit();
		result_t r;
		if (!in_unit)
			return;
		r = '0;
		r.kind             = KIND_END;
		r.length_saturated = len_sat;
		if (longint'(unit_len) > longint'(OUT_LEN_MAX)) begin
			r.unit_length      = OUT_LEN_MAX;
			r.length_saturated = 1'b1;
		end else begin
			r.unit_length = UNIT_LEN_W'(unit_len);
		end
		r.long_prefix        = long_code;
		r.hdr_top_bit        = hdr_byte[7];
		r.reference_priority = hdr_byte[6:5];
		r.unit_type          = hdr_byte[4:0];
		units_seen++;
		awaited_results.push_back(r);
	endfunction

	// one stream byte through the start-code window
	function automatic void split_byte(input logic [7:0] b, input logic eos);
		int unsigned before_n;
		int unsigned c;
		logic        four;
		logic        three;
		before_n = awaited_results.size();
		c        = win_fill;
		four  = (c == 3) && win[0] == SC_ZERO && win[1] == SC_ZERO && win[2] == SC_ZERO
		        && b == SC_ONE;
		three = !four && (c >= 2) && win[c-2] == SC_ZERO && win[c-1] == SC_ZERO
		        && b == SC_ONE;
		if (four || three) begin
			// short code behind a full window: oldest byte still belongs to the old unit
			if (three && c == 3)
				emit_unit_byte(win[0]);
			close_unit();
			in_unit   = 1'b1;
			unit_len  = '0;
			len_sat   = 1'b0;
			hdr_byte  = '0;
			long_code = four;
			win       = '{default: '0};
			c         = 0;
		end else if (c == 3) begin
			emit_unit_byte(win[0]);
			win[0] = win[1];
			win[1] = win[2];
			win[2] = b;
		end else begin
			win[c] = b;
			c++;
		end
		win_fill = c;
		if (eos) begin
			for (int i = 0; i < c; i++)
				emit_unit_byte(win[i]);
			close_unit();
			clear_unit_state();
		end
		if (awaited_results.size() > before_n)
			awaited_results[$].last_result = 1'b1;
	endfunction

	function automatic void cmp_field(input string name, input longint unsigned want,
	                                  input longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			clear_unit_state();
			awaited_results.delete();
			mismatch_count = 0;
			results_seen   = 0;
			units_seen     = 0;
		end else begin
			if (s_tvalid && s_tready)
				split_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = '0;
				got.kind               = m_tuser[0];
				got.first_of_unit      = m_tuser[1];
				got.payload_byte       = m_tdata[7:0];
				got.unit_length        = m_tdata[31:8];
				got.length_saturated   = m_tdata[32];
				got.long_prefix        = m_tdata[33];
				got.hdr_top_bit        = m_tdata[34];
				got.reference_priority = m_tdata[36:35];
				got.unit_type          = m_tdata[41:37];
				got.last_result        = m_tlast;
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result with nothing awaited: tdata 0x%0h tuser 0x%0h", m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					cmp_field("kind", want.kind, got.kind);
					cmp_field("payload_byte", want.payload_byte, got.payload_byte);
					cmp_field("first_of_unit", want.first_of_unit, got.first_of_unit);
					cmp_field("unit_length", want.unit_length, got.unit_length);
					cmp_field("length_saturated", want.length_saturated, got.length_saturated);
					cmp_field("long_prefix", want.long_prefix, got.long_prefix);
					cmp_field("hdr_top_bit", want.hdr_top_bit, got.hdr_top_bit);
					cmp_field("reference_priority", want.reference_priority,
					          got.reference_priority);
					cmp_field("unit_type", want.unit_type, got.unit_type);
					cmp_field("last_result", want.last_result, got.last_result);
				end
			end
		end
		awaited_count = awaited_results.size();
	end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the Annex B splitter: clock, reset, byte stimulus, output stalls, verdict.
`timescale 1ns / 100ps

module testbench;
	import nalsp_pkg::*;

	localparam int LEN_W       = 24;
	localparam int TARGET_BYTES = 270;
	localparam int HOLD_CYCLES  = 150;  // long receiver stall, well past the block's buffering
	localparam int TAIL_CYCLES  = 20;   // input register, output register and some margin

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = '0;   // [7:0] stream_byte
	logic               s_tlast  = 1'b0; // end_of_stream
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;         // payload, length, flags, header fields
	logic [TUSER_W-1:0] m_tuser;         // [0] kind, [1] first_of_unit
	logic               m_tlast;         // last_result

	int unsigned mismatches;
	int unsigned awaited;
	int unsigned results_seen;
	int unsigned units_seen;

	// sender bookkeeping
	int unsigned bytes_sent   = 0;
	int unsigned streams_sent = 0;
	int unsigned burst_left   = 0;
	bit          hold_on      = 1'b0;  // receiver is in its long stall
	bit          hold_done    = 1'b0;

	logic [7:0] stream_buf [$];

	annexb_nal_unit_splitter_top #(.LENGTH_WIDTH(LEN_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	nal_split_checker #(.LENGTH_WIDTH(LEN_W)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatches),
		.awaited_count  (awaited),
		.results_seen   (results_seen),
		.units_seen     (units_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop; a correct run needs a small fraction of this
	initial begin
		#5ms;
		$display("timeout: %0d results still awaited", awaited);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one byte and hold it until the transaction completes. The sender works in
	// bursts; between bursts valid drops for a random gap, unless the receiver is in its
	// long stall, when the byte stream keeps coming so the block backs up.
	task automatic put_byte(input logic [7:0] b, input logic eos);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0 && !hold_on) begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom_range(0, 255));
				s_tlast  <= 1'($urandom_range(0, 1));
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
			                                         : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		bytes_sent++;
	endtask

	// send the buffered stream, end of stream on its last byte
	task automatic send_stream();
		for (int i = 0; i < stream_buf.size(); i++)
			put_byte(stream_buf[i], i == stream_buf.size() - 1);
		stream_buf.delete();
		streams_sent++;
	endtask

	// unit bytes lean towards zeros and ones so start codes turn up inside payload
	function automatic logic [7:0] unit_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick <= 2)
			return SC_ZERO;
		else if (pick == 3)
			return SC_ONE;
		else if (pick == 4)
			return 8'h03;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// Random stream: leading junk, then well-formed units with random content, with the
	// odd broken code or a stream that is pure junk.
	task automatic build_random_stream();
		int unsigned units;
		int unsigned body;
		repeat ($urandom_range(0, 3))
			stream_buf.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 12))
				stream_buf.push_back(unit_byte());
		end else begin
			units = $urandom_range(1, 4);
			repeat (units) begin
				if ($urandom_range(0, 1))
					stream_buf.push_back(SC_ZERO);
				stream_buf.push_back(SC_ZERO);
				stream_buf.push_back(SC_ZERO);
				stream_buf.push_back(SC_ONE);
				body = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
				if (body != 0)
					stream_buf.push_back(8'($urandom_range(0, 255)));  // header byte, any value
				repeat (body > 1 ? body - 1 : 0)
					stream_buf.push_back(unit_byte());
				// broken code: zeros not followed by 01
				if ($urandom_range(0, 9) == 0) begin
					stream_buf.push_back(SC_ZERO);
					stream_buf.push_back(SC_ZERO);
					stream_buf.push_back(($urandom_range(0, 1) != 0) ? 8'h02 : SC_ZERO);
				end
			end
		end
		if (stream_buf.size() == 0)
			stream_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// Receiver: stretches of always-ready, coin-toss and a fixed one-in-three stall
	// pattern. Once enough traffic has gone by, one long hold-off backs the block up.
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned phase;
		wait (arst_n);
		phase = 0;
		forever begin
			if (!hold_done && bytes_sent >= 60) begin
				hold_on   = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on   = 1'b0;
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(5, 40);
			repeat (span) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= (phase % 3 != 0);
				endcase
				phase++;
				@(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [7:0] directed_a [] = '{
			8'hFF,                          // junk ahead of the first start code
			8'h00, 8'h00, 8'h00, 8'h01,     // four-byte code
			8'hFF, 8'h00, 8'h00, 8'h02,     // all-ones header, 00 00 02 is plain payload
			8'h00, 8'h00, 8'h01,            // three-byte code behind a full window
			8'h00, 8'h00, 8'h01,            // code straight after a code: empty unit
			8'h00, 8'h01, 8'h00, 8'h00,     // all-zero header
			8'h00, 8'h01                    // four-byte code as the very last byte
		};
		logic [7:0] directed_c [] = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h88};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed streams
		foreach (directed_a[i])
			stream_buf.push_back(directed_a[i]);
		send_stream();
		stream_buf.push_back(SC_ZERO);        // lone byte ending a stream, no unit open
		send_stream();
		foreach (directed_c[i])               // window flushed into the unit at end of stream
			stream_buf.push_back(directed_c[i]);
		send_stream();

		// random streams
		while (bytes_sent < TARGET_BYTES) begin
			build_random_stream();
			send_stream();
		end
		s_tvalid <= 1'b0;

		do @(negedge clk); while (awaited != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("Covered %0d stream bytes in %0d streams, one long output stall included.",
		         bytes_sent, streams_sent);
		$display("Checked %0d output transactions closing %0d units.", results_seen, units_seen);
		if (mismatches == 0 && awaited == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/nalsp_pkg.sv
design/nalsp_in_reg.sv
design/nalsp_engine.sv
design/nalsp_out_reg.sv
design/annexb_nal_unit_splitter_top.sv
sim/nal_split_checker.sv
sim/testbench.sv
